/* hw/rtl/deq_pkg.sv */
// Shared types and constants for the double-ended queue.
`default_nettype none
package deq_pkg;

	// Storage depth; the 7-bit count and capacity fields bound it.
	localparam int DEPTH  = 64;

	localparam int DATA_W = 32;
	localparam int CNT_W  = 7;
	localparam int OP_W   = 3;
	localparam int ST_W   = 2;

	localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_REAR  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_REAR   = 3'd3,
		OP_PEEK_FRONT = 3'd4,
		OP_PEEK_REAR  = 3'd5
	} op_e;

	typedef enum logic [ST_W-1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_e;

	typedef enum logic [1:0] {
		KIND_NOP  = 2'd0,
		KIND_PUSH = 2'd1,
		KIND_POP  = 2'd2,
		KIND_PEEK = 2'd3
	} kind_e;

	// Classified command handed from the front to the back.
	typedef struct packed {
		kind_e                    kind;
		logic                     at_rear;
		logic signed [DATA_W-1:0] value;
	} cmd_t;

	// One result item.
	typedef struct packed {
		logic                     is_full;
		logic                     is_empty;
		logic [CNT_W-1:0]         entry_count;
		status_e                  status;
		logic signed [DATA_W-1:0] read_value;
	} result_t;

endpackage
`default_nettype wire

/* hw/rtl/deq_front.sv */
// Front end: accepts input items, classifies the opcode and queues commands.
`default_nettype none
module deq_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [deq_pkg::OP_W-1:0]      in_opcode,
	input  wire logic signed [deq_pkg::DATA_W-1:0] in_value,
	output logic                               cmd_valid,
	input  wire logic                          cmd_ready,
	output deq_pkg::cmd_t                      cmd
);
	import deq_pkg::*;

	cmd_t       fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	cmd_t       decoded;
	logic       push_en;
	logic       pop_en;

	// Classify the opcode into kind and end.
	always_comb begin
		decoded.value   = in_value;
		decoded.kind    = KIND_NOP;
		decoded.at_rear = 1'b0;
		unique case (in_opcode)
			OP_PUSH_FRONT: begin
				decoded.kind = KIND_PUSH;
			end
			OP_PUSH_REAR: begin
				decoded.kind    = KIND_PUSH;
				decoded.at_rear = 1'b1;
			end
			OP_POP_FRONT: begin
				decoded.kind = KIND_POP;
			end
			OP_POP_REAR: begin
				decoded.kind    = KIND_POP;
				decoded.at_rear = 1'b1;
			end
			OP_PEEK_FRONT: begin
				decoded.kind = KIND_PEEK;
			end
			OP_PEEK_REAR: begin
				decoded.kind    = KIND_PEEK;
				decoded.at_rear = 1'b1;
			end
			default: begin
				decoded.kind = KIND_NOP;
			end
		endcase
	end

	assign in_ready  = (fill_q != 2'd2);
	assign cmd_valid = (fill_q != 2'd0);
	assign cmd       = fifo_q[rd_ptr_q];
	assign push_en   = in_valid && in_ready;
	assign pop_en    = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push_en) begin
			fifo_q[wr_ptr_q] <= decoded;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push_en) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop_en) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push_en && !pop_en) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop_en && !push_en) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/deq_back.sv */
// Back end: circular buffer storage, head and count update, result registers.
`default_nettype none
module deq_back (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic [deq_pkg::CNT_W-1:0] cfg_capacity,
	input  wire logic                     cmd_valid,
	output logic                          cmd_ready,
	input  wire deq_pkg::cmd_t            cmd,
	output logic                          res_valid,
	input  wire logic                     res_ready,
	output deq_pkg::result_t              res
);
	import deq_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SW = ((AW > CNT_W) ? AW : CNT_W) + 1;
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	logic signed [DATA_W-1:0] mem [DEPTH];

	logic [AW-1:0]    head_q;
	logic [CNT_W-1:0] cnt_q;

	logic                     valid_s1;
	logic                     rd_en_s1;
	logic signed [DATA_W-1:0] rdata_s1;
	status_e                  status_s1;
	logic [CNT_W-1:0]         cnt_s1;
	logic                     empty_s1;
	logic                     full_s1;

	logic    out_valid_q;
	result_t out_q;

	logic [CNT_W-1:0] eff_cap;
	logic [SW-1:0]    tail_sum;
	logic [AW-1:0]    tail;
	logic [AW-1:0]    rear;
	logic [AW-1:0]    head_dec;
	logic [AW-1:0]    head_inc;
	logic             full_now;
	logic             empty_now;
	logic             issue;
	logic             adv_s1;
	logic             do_write;
	logic             do_read;
	logic [AW-1:0]    waddr;
	logic [AW-1:0]    raddr;
	logic [AW-1:0]    head_d;
	logic [CNT_W-1:0] cnt_d;
	status_e          st_d;

	// Capacity saturates at the storage depth.
	assign eff_cap = (32'(cfg_capacity) > DEPTH) ? CNT_W'(DEPTH) : cfg_capacity;

	assign tail_sum  = SW'(head_q) + SW'(cnt_q);
	assign tail      = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
	assign rear      = (tail == '0) ? LAST : tail - AW'(1);
	assign head_dec  = (head_q == '0) ? LAST : head_q - AW'(1);
	assign head_inc  = (head_q == LAST) ? '0 : head_q + AW'(1);
	assign full_now  = (cnt_q >= eff_cap);
	assign empty_now = (cnt_q == '0);

	assign adv_s1    = valid_s1 && (!out_valid_q || res_ready);
	assign cmd_ready = !valid_s1 || adv_s1;
	assign issue     = cmd_valid && cmd_ready;

	always_comb begin
		do_write = 1'b0;
		do_read  = 1'b0;
		waddr    = tail;
		raddr    = head_q;
		head_d   = head_q;
		cnt_d    = cnt_q;
		st_d     = ST_OK;
		unique case (cmd.kind)
			KIND_PUSH: begin
				if (full_now) begin
					st_d = ST_OVERFLOW;
				end else begin
					do_write = 1'b1;
					cnt_d    = cnt_q + CNT_W'(1);
					if (!cmd.at_rear) begin
						waddr  = head_dec;
						head_d = head_dec;
					end
				end
			end
			KIND_POP: begin
				if (empty_now) begin
					st_d = ST_UNDERFLOW;
				end else begin
					do_read = 1'b1;
					cnt_d   = cnt_q - CNT_W'(1);
					if (cmd.at_rear) begin
						raddr = rear;
					end else begin
						head_d = head_inc;
					end
				end
			end
			KIND_PEEK: begin
				if (empty_now) begin
					st_d = ST_UNDERFLOW;
				end else begin
					do_read = 1'b1;
					if (cmd.at_rear) begin
						raddr = rear;
					end
				end
			end
			KIND_NOP: begin
			end
		endcase
	end

	// Storage: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (issue && do_write) begin
			mem[waddr] <= cmd.value;
		end
		if (issue && do_read) begin
			rdata_s1 <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_en_s1  <= do_read;
			status_s1 <= st_d;
			cnt_s1    <= cnt_d;
			empty_s1  <= (cnt_d == '0);
			full_s1   <= (cnt_d >= eff_cap);
		end
		if (adv_s1) begin
			out_q.read_value  <= rd_en_s1 ? rdata_s1 : '0;
			out_q.status      <= status_s1;
			out_q.entry_count <= cnt_s1;
			out_q.is_empty    <= empty_s1;
			out_q.is_full     <= full_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			cnt_q       <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				head_q <= head_d;
				cnt_q  <= cnt_d;
			end
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

endmodule
`default_nettype wire

/* hw/rtl/double_ended_queue.sv */
// Top level of the double-ended queue: stream ports, APB capacity register.
//
// Input stream (s_axis): one item per operation. tuser carries the opcode
// (push front/rear, pop front/rear, peek front/rear), tdata the word to push.
// Output stream (m_axis): exactly one item per input item, in order. tdata
// carries the word read, the entry count, and the empty and full flags;
// tuser carries the status (ok, overflow, underflow).
// APB port: one register at byte address 0, the capacity (7 bits, saturates
// at DEPTH). Write it only while no item is in flight.
// Each item passes the command queue, the result stage and the output register.
// Throughput: one item per cycle while the receiver keeps up; the back end
// updates the storage for an item as it issues, and its read data is registered.
// Reset: empty queue, head at zero, capacity 64; storage is not cleared and
// needs no clearing pass.
// Stall: a two-entry command queue parts input from execution, and a result
// stage plus the output register hold results; when the receiver stalls, the
// back end stops and the command queue fills, then s_axis_tready drops.
`default_nettype none
module double_ended_queue (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // [31:0] push_value
	input  wire logic [2:0]  s_axis_tuser,  // [2:0] opcode
	// Output stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [47:0]      m_axis_tdata,  // [31:0] read_value, [38:32] entry_count,
	                                        // [39] is_empty, [40] is_full, rest zero
	output logic [1:0]       m_axis_tuser,  // [1:0] status
	// Configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import deq_pkg::*;

	logic [CNT_W-1:0] capacity_q;
	logic             cmd_valid;
	logic             cmd_ready;
	cmd_t             cmd;
	logic             res_valid;
	result_t          res;
	logic             reg_sel;

	// Register index is the word address; only index zero exists.
	assign reg_sel = (paddr[2] == 1'b0);
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? {{(32 - CNT_W){1'b0}}, capacity_q} : 32'd0;

	// Latch capacity on the access phase of a write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			capacity_q <= pwdata[CNT_W-1:0];
		end
	end

	// Accept and classify.
	deq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_opcode (s_axis_tuser),
		.in_value  (s_axis_tdata),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	// Execute against the circular buffer.
	deq_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_capacity (capacity_q),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.cmd          (cmd),
		.res_valid    (res_valid),
		.res_ready    (m_axis_tready),
		.res          (res)
	);

	// Pack the result, lowest field first, padded to whole bytes.
	assign m_axis_tvalid = res_valid;
	assign m_axis_tdata  = {7'd0, res.is_full, res.is_empty, res.entry_count, res.read_value};
	assign m_axis_tuser  = res.status;

endmodule
`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for the double-ended queue: directed and random operations.
`timescale 1ns / 1ps
`default_nettype none
module tb;
	import deq_pkg::*;

	localparam int          CLK_HALF     = 10;
	localparam int          CYCLE_LIMIT  = 200000;
	// Quiet time after the last result, before touching the register.
	localparam int          SETTLE       = 6;
	localparam logic [2:0]  CAP_ADDR     = 3'd0;
	// Opcodes with no operation behind them.
	localparam logic [2:0]  OP_UNUSED_LO = 3'd6;
	localparam logic [2:0]  OP_UNUSED_HI = 3'd7;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;   // [31:0] push_value
	logic [2:0]  s_axis_tuser;   // [2:0] opcode
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;   // [31:0] read_value, [38:32] entry_count,
	                             // [39] is_empty, [40] is_full, rest zero
	logic [1:0]  m_axis_tuser;   // [1:0] status
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// Shadow copy of the queue contents and the capacity register.
	logic [31:0] shadow_words [DEPTH];
	logic [5:0]  shadow_head;
	logic [6:0]  shadow_count;
	logic [6:0]  shadow_cap;

	result_t     outcome_q [$];
	result_t     oldest_outcome;
	int          errors;
	int          cycle_count;
	int          send_idle_pct;
	int          recv_idle_pct;
	int          rx_hold_left;

	double_ended_queue uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #CLK_HALF clk = ~clk;

	// Apply one operation to the shadow queue and return the result it must give.
	function automatic result_t apply_deque_op(input logic [2:0] op, input logic [31:0] word);
		result_t    r;
		logic [6:0] eff_cap;
		logic [5:0] rear_slot;
		logic       was_full;
		logic       was_empty;
		eff_cap   = (shadow_cap > 7'(DEPTH)) ? 7'(DEPTH) : shadow_cap;
		was_full  = shadow_count >= eff_cap;
		was_empty = shadow_count == 7'd0;
		// Rear entry sits count-1 slots past the head, wrapped to the store size.
		rear_slot = shadow_head + shadow_count[5:0] - 6'd1;
		r.read_value = '0;
		r.status     = ST_OK;
		case (op)
			OP_PUSH_FRONT, OP_PUSH_REAR: begin
				if (was_full) begin
					r.status = ST_OVERFLOW;
				end else if (op == OP_PUSH_FRONT) begin
					shadow_head               = shadow_head - 6'd1;
					shadow_words[shadow_head] = word;
					shadow_count              = shadow_count + 7'd1;
				end else begin
					shadow_words[rear_slot + 6'd1] = word;
					shadow_count                   = shadow_count + 7'd1;
				end
			end
			OP_POP_FRONT, OP_PEEK_FRONT: begin
				if (was_empty) begin
					r.status = ST_UNDERFLOW;
				end else begin
					r.read_value = shadow_words[shadow_head];
					if (op == OP_POP_FRONT) begin
						shadow_head  = shadow_head + 6'd1;
						shadow_count = shadow_count - 7'd1;
					end
				end
			end
			OP_POP_REAR, OP_PEEK_REAR: begin
				if (was_empty) begin
					r.status = ST_UNDERFLOW;
				end else begin
					r.read_value = shadow_words[rear_slot];
					if (op == OP_POP_REAR)
						shadow_count = shadow_count - 7'd1;
				end
			end
			default: ;
		endcase
		r.entry_count = shadow_count;
		r.is_empty    = shadow_count == 7'd0;
		r.is_full     = shadow_count >= eff_cap;
		return r;
	endfunction

	// Offer one item, with a random gap first; predict its result once it is taken.
	// tvalid stays high on return so a following item goes out back to back.
	task automatic send_item(input logic [2:0] op, input logic [31:0] word);
		result_t r;
		if ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= word;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		r = apply_deque_op(op, word);
		outcome_q.push_back(r);
	endtask

	// Drop tvalid at once, then hold until every result is back and the pipe is quiet.
	task automatic drain;
		s_axis_tvalid <= 1'b0;
		while (outcome_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Setup cycle, then access cycle; the register takes the value at the access edge.
	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == CAP_ADDR)
			shadow_cap = data[6:0];
	endtask

	task automatic set_capacity(input logic [6:0] cap);
		drain();
		apb_write(CAP_ADDR, {25'd0, cap});
	endtask

	// Mostly random words, with the sign and all-ones extremes mixed in.
	function automatic logic [31:0] pick_word;
		case ($urandom_range(19))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return 32'h0000_0000;
			3:       return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// Empty queue first, with the unused opcodes, then both ends and both sign extremes.
	task automatic test_empty_and_ends;
		send_item(OP_PEEK_FRONT, 32'h1234_5678);
		send_item(OP_PEEK_REAR,  32'h0);
		send_item(OP_POP_FRONT,  32'h0);
		send_item(OP_POP_REAR,   32'hFFFF_FFFF);
		send_item(OP_UNUSED_LO,  32'hDEAD_BEEF);
		send_item(OP_UNUSED_HI,  32'h0);
		send_item(OP_PUSH_FRONT, 32'h8000_0000);
		send_item(OP_PUSH_REAR,  32'h7FFF_FFFF);
		send_item(OP_PUSH_FRONT, 32'hAAAA_AAAA);
		send_item(OP_PUSH_REAR,  32'h5555_5555);
		send_item(OP_PUSH_FRONT, 32'h0000_0000);
		send_item(OP_PUSH_REAR,  32'hFFFF_FFFF);
		send_item(OP_PEEK_FRONT, 32'h0);
		send_item(OP_PEEK_REAR,  32'h0);
		send_item(OP_POP_REAR,   32'h0);
		send_item(OP_POP_FRONT,  32'h0);
		send_item(OP_POP_FRONT,  32'h0);
		send_item(OP_POP_REAR,   32'h0);
	endtask

	// Two words are held on entry: fill a tiny deque, then shrink the capacity under them.
	task automatic test_capacity_edges;
		set_capacity(7'd2);
		send_item(OP_PUSH_REAR,  32'h0000_0001);
		send_item(OP_UNUSED_HI,  32'h0);
		// Capacity below the count: nothing is lost, the deque just reads full.
		set_capacity(7'd1);
		send_item(OP_PUSH_FRONT, 32'h0000_0002);
		send_item(OP_POP_FRONT,  32'h0);
		// Capacity zero: always full, pushes overflow, pops still drain it.
		set_capacity(7'd0);
		send_item(OP_PUSH_REAR,  32'h0000_0003);
		send_item(OP_PEEK_REAR,  32'h0);
		send_item(OP_POP_REAR,   32'h0);
		send_item(OP_PEEK_FRONT, 32'h0);
	endtask

	// Random operations in chunks that lean toward pushing, popping or neither,
	// so the count sweeps between empty and full.
	task automatic test_random_ops(input int n_items, input logic [6:0] cap);
		int         push_weight;
		int         roll;
		logic [2:0] op;
		set_capacity(cap);
		push_weight = 50;
		for (int i = 0; i < n_items; i++) begin
			if (i % 80 == 0) begin
				case ($urandom_range(2))
					0:       push_weight = 80;
					1:       push_weight = 20;
					default: push_weight = 50;
				endcase
			end
			roll = $urandom_range(99);
			if (roll < 3)
				op = ($urandom_range(1) != 0) ? OP_UNUSED_HI : OP_UNUSED_LO;
			else if (roll < push_weight)
				op = ($urandom_range(1) != 0) ? OP_PUSH_REAR : OP_PUSH_FRONT;
			else begin
				case ($urandom_range(5))
					0, 1:    op = OP_POP_FRONT;
					2, 3:    op = OP_POP_REAR;
					4:       op = OP_PEEK_FRONT;
					default: op = OP_PEEK_REAR;
				endcase
			end
			send_item(op, pick_word());
		end
	endtask

	// Stall the receiver for a long stretch while items keep coming, so the
	// internal queue fills and the input side must back off.
	task automatic test_backpressure;
		set_capacity(7'd64);
		rx_hold_left = 80;
		for (int i = 0; i < 16; i++)
			send_item(($urandom_range(1) != 0) ? OP_PUSH_REAR : OP_PUSH_FRONT, pick_word());
		for (int i = 0; i < 16; i++)
			send_item((i % 2 != 0) ? OP_POP_FRONT : OP_PEEK_REAR, 32'h0);
	endtask

	// Receiver: honor a requested hold first, otherwise stall at random.
	always @(posedge clk) begin
		if (rx_hold_left > 0) begin
			m_axis_tready <= 1'b0;
			rx_hold_left--;
		end else begin
			m_axis_tready <= $urandom_range(99) >= recv_idle_pct;
		end
	end

	// Check every accepted result against the oldest prediction, field by field.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (outcome_q.size() == 0) begin
				$display("%0t: result item with none pending: tdata=%h tuser=%h",
					$time, m_axis_tdata, m_axis_tuser);
				errors++;
			end else begin
				oldest_outcome = outcome_q.pop_front();
				if (m_axis_tdata[31:0] !== oldest_outcome.read_value) begin
					$display("%0t: read_value expected %h actual %h",
						$time, oldest_outcome.read_value, m_axis_tdata[31:0]);
					errors++;
				end
				if (m_axis_tuser !== oldest_outcome.status) begin
					$display("%0t: status expected %0d actual %0d",
						$time, oldest_outcome.status, m_axis_tuser);
					errors++;
				end
				if (m_axis_tdata[38:32] !== oldest_outcome.entry_count) begin
					$display("%0t: entry_count expected %0d actual %0d",
						$time, oldest_outcome.entry_count, m_axis_tdata[38:32]);
					errors++;
				end
				if (m_axis_tdata[39] !== oldest_outcome.is_empty) begin
					$display("%0t: is_empty expected %b actual %b",
						$time, oldest_outcome.is_empty, m_axis_tdata[39]);
					errors++;
				end
				if (m_axis_tdata[40] !== oldest_outcome.is_full) begin
					$display("%0t: is_full expected %b actual %b",
						$time, oldest_outcome.is_full, m_axis_tdata[40]);
					errors++;
				end
				if (m_axis_tdata[47:41] !== 7'd0) begin
					$display("%0t: tdata pad expected %h actual %h",
						$time, 7'd0, m_axis_tdata[47:41]);
					errors++;
				end
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results pending", $time, outcome_q.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		m_axis_tready = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		errors        = 0;
		cycle_count   = 0;
		rx_hold_left  = 0;
		shadow_head   = '0;
		shadow_count  = '0;
		shadow_cap    = CAP_RESET;
		foreach (shadow_words[i])
			shadow_words[i] = '0;

		// Sender idles lightly, receiver heavily.
		send_idle_pct = 15;
		recv_idle_pct = 52;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_and_ends();
		test_capacity_edges();
		// Capacity above the store size saturates; push-heavy chunks reach full.
		test_random_ops(350, 7'd127);
		test_random_ops(200, 7'd1);

		// Swap the idling between the two sides.
		drain();
		send_idle_pct = 52;
		recv_idle_pct = 15;
		test_random_ops(300, 7'($urandom_range(3, 63)));
		test_random_ops(60, 7'd0);

		// No idling at all, then a long receiver stall.
		drain();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_backpressure();
		test_random_ops(380, 7'd64);
		test_random_ops(100, 7'd2);

		drain();
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
`default_nettype wire
